// ===== rtl/sepm_pkg.sv =====
// Shared types and constants of the scan-line edge-peak motion block.
// No dependencies; every module of the block but sepm_ram imports this package.
package sepm_pkg;

    // Fixed field widths
    localparam int PIX_W       = 8;   // one color channel
    localparam int STR_W       = 10;  // edge strength, up to 3 * 255
    localparam int CNT_W       = 9;   // line count register
    localparam int MOTION_W    = 13;  // motion result, two's complement
    localparam int QUEUE_DEPTH = 4;   // line records between front and back

    // Configuration register indexes
    localparam logic CFG_HLINES = 1'b0;
    localparam logic CFG_VLINES = 1'b1;

    // Line record queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACC,
        BK_START,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ===== rtl/sepm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sepm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sepm_fifo.sv =====
// Short register queue carrying line records from the front to the back end.
// Depends on sepm_pkg for the status struct.
module sepm_fifo import sepm_pkg::*; #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_B = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output t_queue_status    o_status
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_B-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == CNT_B'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rptr];

    // Pointer and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_B'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_B'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/sepm_front.sv =====
// Front end: per-pixel edge strength, per-line peak tracking, line records.
// Depends on sepm_pkg for field widths.
module sepm_front import sepm_pkg::*; #(
    parameter int MAX_LINES       = 256,
    parameter int MAX_LINE_LENGTH = 4096,
    localparam int POS_W  = $clog2(MAX_LINE_LENGTH),
    localparam int LIDX_W = $clog2(MAX_LINES + 1),
    localparam int ADDR_W = $clog2(2 * MAX_LINES),
    localparam int REC_W  = 3 + ADDR_W + POS_W + CNT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic             i_axis,
    input  logic             i_line_end,
    input  logic             i_axis_end,
    input  logic [CNT_W-1:0] i_hlines,
    input  logic [CNT_W-1:0] i_vlines,
    output logic             o_push,
    output logic [REC_W-1:0] o_rec
);

    typedef struct packed {
        logic              axis;
        logic              axis_end;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
    } t_line_rec;

    logic [PIX_W-1:0]  r_prev_r, n_prev_r;
    logic [PIX_W-1:0]  r_prev_g, n_prev_g;
    logic [PIX_W-1:0]  r_prev_b, n_prev_b;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [STR_W-1:0]  r_best_str, n_best_str;
    logic [POS_W-1:0]  r_best_pos, n_best_pos;
    logic [LIDX_W-1:0] r_line_idx, n_line_idx;

    logic [PIX_W-1:0]  ad_r, ad_g, ad_b;
    logic [STR_W-1:0]  strength;
    logic              upd;
    logic [POS_W-1:0]  peak_pos;
    logic [CNT_W-1:0]  count_sel;
    logic              ends;
    t_line_rec         rec;

    // Edge strength against the previous pixel; zero at line start
    always_comb begin
        ad_r = (i_red   > r_prev_r) ? i_red   - r_prev_r : r_prev_r - i_red;
        ad_g = (i_green > r_prev_g) ? i_green - r_prev_g : r_prev_g - i_green;
        ad_b = (i_blue  > r_prev_b) ? i_blue  - r_prev_b : r_prev_b - i_blue;
        if (r_pos == '0) begin
            strength = '0;
        end else begin
            strength = STR_W'(ad_r) + STR_W'(ad_g) + STR_W'(ad_b);
        end
        upd      = (strength > r_best_str);
        peak_pos = upd ? r_pos : r_best_pos;
    end

    // Line record built on the closing pixel of a line
    always_comb begin
        count_sel    = i_axis ? i_vlines : i_hlines;
        ends         = i_line_end || i_axis_end;
        rec.axis     = i_axis;
        rec.axis_end = i_axis_end;
        rec.hit      = (32'(r_line_idx) < 32'(count_sel)) && (32'(r_line_idx) < MAX_LINES);
        rec.addr     = (i_axis ? ADDR_W'(MAX_LINES) : '0) + ADDR_W'(r_line_idx);
        rec.pos      = peak_pos;
        rec.count    = count_sel;
    end

    assign o_push = i_accept && ends;
    assign o_rec  = rec;

    // Per-line state update
    always_comb begin
        n_prev_r   = r_prev_r;
        n_prev_g   = r_prev_g;
        n_prev_b   = r_prev_b;
        n_pos      = r_pos;
        n_best_str = r_best_str;
        n_best_pos = r_best_pos;
        n_line_idx = r_line_idx;
        if (i_accept) begin
            if (ends) begin
                n_prev_r   = '0;
                n_prev_g   = '0;
                n_prev_b   = '0;
                n_pos      = '0;
                n_best_str = '0;
                n_best_pos = '0;
                if (i_axis_end) begin
                    n_line_idx = '0;
                end else if (32'(r_line_idx) < MAX_LINES) begin
                    n_line_idx = r_line_idx + LIDX_W'(1);
                end
            end else begin
                n_prev_r = i_red;
                n_prev_g = i_green;
                n_prev_b = i_blue;
                if (upd) begin
                    n_best_str = strength;
                    n_best_pos = r_pos;
                end
                // position saturates on over-long lines
                if (r_pos < POS_W'(MAX_LINE_LENGTH - 1)) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_r   <= '0;
            r_prev_g   <= '0;
            r_prev_b   <= '0;
            r_pos      <= '0;
            r_best_str <= '0;
            r_best_pos <= '0;
            r_line_idx <= '0;
        end else begin
            r_prev_r   <= n_prev_r;
            r_prev_g   <= n_prev_g;
            r_prev_b   <= n_prev_b;
            r_pos      <= n_pos;
            r_best_str <= n_best_str;
            r_best_pos <= n_best_pos;
            r_line_idx <= n_line_idx;
        end
    end

endmodule

// ===== rtl/sepm_div.sv =====
// Restoring divider, one quotient bit per cycle: signed sum over line count.
// Depends on sepm_pkg for the count and result widths.
module sepm_div import sepm_pkg::*; #(
    parameter int SUM_W = 22,
    localparam int CYC_W = (SUM_W > 1) ? $clog2(SUM_W) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic [CNT_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic signed [MOTION_W-1:0] o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [CYC_W-1:0]           r_cyc;
    logic [SUM_W-1:0]           r_mag;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_div;
    logic                       r_neg;
    logic signed [MOTION_W-1:0] r_quot;

    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;
    logic [CNT_W-1:0] rem_nx;
    logic [SUM_W-1:0] quo_nx;
    logic [SUM_W-1:0] quo_signed;
    logic             last;

    // One restoring step
    always_comb begin
        trial      = {r_rem, r_mag[SUM_W-1]};
        diff       = trial - {1'b0, r_div};
        ge         = (trial >= {1'b0, r_div});
        rem_nx     = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_nx     = {r_quo[SUM_W-2:0], ge};
        quo_signed = r_neg ? (~quo_nx + SUM_W'(1)) : quo_nx;
        last       = (r_cyc == CYC_W'(SUM_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cyc  <= '0;
            end else if (r_busy) begin
                r_cyc <= r_cyc + CYC_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude, remainder, quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_mag <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[SUM_W-2:0], 1'b0};
            r_rem <= rem_nx;
            r_quo <= quo_nx;
            if (last) begin
                // zero line count gives zero motion
                r_quot <= (r_div == '0) ? '0 : quo_signed[MOTION_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ===== rtl/sepm_back.sv =====
// Back end: prior-peak store, displacement sum, per-axis divide, result register.
// Depends on sepm_pkg, sepm_ram and sepm_div.
module sepm_back import sepm_pkg::*; #(
    parameter int MAX_LINES       = 256,
    parameter int MAX_LINE_LENGTH = 4096,
    localparam int POS_W  = $clog2(MAX_LINE_LENGTH),
    localparam int LIDX_W = $clog2(MAX_LINES + 1),
    localparam int DEPTH  = 2 * MAX_LINES,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int SUM_W  = POS_W + LIDX_W + 1,
    localparam int REC_W  = 3 + ADDR_W + POS_W + CNT_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_queue_status              i_q_status,
    input  logic [REC_W-1:0]           i_q_head,
    output logic                       o_q_pop,
    output logic                       o_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [MOTION_W-1:0] o_motion,
    output logic                       o_motion_axis
);

    typedef struct packed {
        logic              axis;
        logic              axis_end;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
    } t_line_rec;

    t_back_state             r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    t_line_rec               r_rec;
    t_line_rec               head;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_out_valid;
    logic signed [MOTION_W-1:0] r_motion;
    logic                    r_motion_axis;

    logic                    out_free;
    logic                    pop;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [POS_W-1:0]        ram_wdata;
    logic [POS_W-1:0]        ram_rdata;
    logic                    acc;
    logic                    div_start;
    logic                    div_done;
    logic signed [MOTION_W-1:0] div_quot;
    logic                    load_out;
    logic signed [POS_W:0]   delta;

    assign head     = i_q_head;
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    if (head.hit) begin
                        n_state = BK_ACC;
                    end else if (head.axis_end) begin
                        n_state = BK_START;
                    end
                end
            end
            BK_ACC: begin
                n_state = r_rec.axis_end ? BK_START : BK_IDLE;
            end
            BK_START: begin
                n_state = BK_DIV;
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_rec.addr;
        ram_wdata = r_rec.pos;
        acc       = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        o_ready   = 1'b1;
        case (r_state)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                o_ready   = 1'b0;
            end
            BK_IDLE: begin
                pop = !i_q_status.empty;
            end
            BK_ACC: begin
                ram_we = 1'b1;
                acc    = 1'b1;
            end
            BK_START: begin
                div_start = 1'b1;
            end
            BK_DIV: begin
                div_start = 1'b0;
            end
            BK_OUT: begin
                load_out = out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_q_pop = pop;

    // New peak minus stored peak of the same line
    assign delta = $signed({1'b0, r_rec.pos}) - $signed({1'b0, ram_rdata});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (acc) begin
                r_sum <= r_sum + SUM_W'(delta);
            end else if (load_out) begin
                r_sum <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Record and result payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec <= head;
        end
        if (load_out) begin
            r_motion      <= div_quot;
            r_motion_axis <= r_rec.axis;
        end
    end

    sepm_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (head.addr),
        .o_rdata (ram_rdata)
    );

    sepm_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_rec.count),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign o_out_valid   = r_out_valid;
    assign o_motion      = r_motion;
    assign o_motion_axis = r_motion_axis;

endmodule

// ===== rtl/scanline_edge_peak_motion.sv =====
// Scan-line edge-peak motion estimator. Pixels sampled along horizontal or
// vertical scan lines are taken one per cycle while the input is ready;
// each line's first strongest edge position is compared with that line's
// peak from the previous frame, and at each axis end one beat carries the
// average displacement, signed sum divided by the configured line count (0
// when the count is 0). A counted line end costs the back end a prior-peak
// RAM read, then a write; an axis end adds the shared bit-serial divider
// over SUM_W = log2(MAX_LINE_LENGTH) + log2(MAX_LINES + 1) + 1 bits (22 at
// the defaults). A four-record queue lets the pixel side run on meanwhile;
// input stalls when it fills or while the prior-peak RAM is cleared. After
// reset all 2 * MAX_LINES RAM entries (512 at the defaults) are cleared, and
// no pixel beat is accepted then; configuration writes are taken.
// Depends on sepm_pkg, sepm_fifo, sepm_front and sepm_back.
module scanline_edge_peak_motion import sepm_pkg::*; #(
    parameter int MAX_LINES       = 256,
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    // pixel stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,   // red, green, blue
    input  logic [1:0]       i_s_axis_tuser,   // axis, axis_end
    input  logic             i_s_axis_tlast,   // line_end
    // motion results
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // motion, zero fill
    output logic             o_m_axis_tuser    // motion_axis
);

    localparam int POS_W  = $clog2(MAX_LINE_LENGTH);
    localparam int ADDR_W = $clog2(2 * MAX_LINES);
    localparam int REC_W  = 3 + ADDR_W + POS_W + CNT_W;

    logic [CNT_W-1:0]           r_hlines;
    logic [CNT_W-1:0]           r_vlines;
    logic                       accept;
    logic                       push;
    logic [REC_W-1:0]           rec_in;
    logic [REC_W-1:0]           rec_head;
    logic                       pop;
    t_queue_status              q_status;
    logic                       back_ready;
    logic signed [MOTION_W-1:0] motion;

    // Line count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hlines <= '0;
            r_vlines <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HLINES: r_hlines <= i_cfg_data;
                CFG_VLINES: r_vlines <= i_cfg_data;
                default:    r_hlines <= r_hlines;
            endcase
        end
    end

    assign o_s_axis_tready = back_ready && !q_status.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    sepm_front #(
        .MAX_LINES       (MAX_LINES),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_red      (i_s_axis_tdata[7:0]),
        .i_green    (i_s_axis_tdata[15:8]),
        .i_blue     (i_s_axis_tdata[23:16]),
        .i_axis     (i_s_axis_tuser[0]),
        .i_line_end (i_s_axis_tlast),
        .i_axis_end (i_s_axis_tuser[1]),
        .i_hlines   (r_hlines),
        .i_vlines   (r_vlines),
        .o_push     (push),
        .o_rec      (rec_in)
    );

    sepm_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (rec_in),
        .i_pop    (pop),
        .o_head   (rec_head),
        .o_status (q_status)
    );

    sepm_back #(
        .MAX_LINES       (MAX_LINES),
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_q_head      (rec_head),
        .o_q_pop       (pop),
        .o_ready       (back_ready),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_motion      (motion),
        .o_motion_axis (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{(16 - MOTION_W){1'b0}}, motion};

endmodule
